>>> rtl/dirty_page_bitmap_tracker_unit_assert.svh
// Assertion macros used by the dirty page bitmap tracker unit.
`ifndef DIRTY_PAGE_BITMAP_TRACKER_UNIT_ASSERT_SVH
`define DIRTY_PAGE_BITMAP_TRACKER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Condition a implies condition b at the same clock edge.
`define DPBT_ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: a implies b");
// Condition a implies condition b at the following clock edge.
`define DPBT_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: a implies b next cycle");
`else
`define DPBT_ASSERT_IMPLIES(label, clk, rst, a, b)
`define DPBT_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

>>> rtl/dpbt_pkg.sv
// Package with the constants, codes and types of the dirty page bitmap tracker.
package dpbt_pkg;

   localparam int BITMAP_WORDS = 4;
   localparam int WORD_BITS    = 64;
   localparam int BIT_W        = 6;
   localparam int PAGE_W       = 8;
   localparam int CMD_W        = 2;
   localparam int COUNT_W      = 9;
   localparam int ADDR_W       = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

   localparam logic [CMD_W-1:0] CMD_MARK          = 2'd0;
   localparam logic [CMD_W-1:0] CMD_COLLECT       = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR_FRAME   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESET_SESSION = 2'd3;

   localparam logic OP_SET       = 1'b0;
   localparam logic OP_CLEAR_LOW = 1'b1;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [ADDR_W-1:0]    addr_type;

   typedef struct packed {
      addr_type rd_addr;
      addr_type wr_addr;
      logic     frame_we;
      logic     session_we;
      logic     clear_frame;
      logic     clear_session;
   } dpbt_store_ctrl_type;

   typedef struct packed {
      word_type         frame_word;
      word_type         session_word;
      logic [BIT_W-1:0] bit_index;
      logic             nonzero;
      logic             frame_fresh;
      logic             session_fresh;
   } dpbt_bit_res_type;

endpackage

>>> rtl/dpbt_channel_ifs.sv
// Request and response channel interfaces of the dirty page bitmap tracker.
interface dpbt_req_if import dpbt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [PAGE_W-1:0] page_number;

   modport source (output valid, output cmd, output page_number, input ready);
   modport sink (input valid, input cmd, input page_number, output ready);
endinterface

interface dpbt_rsp_if import dpbt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PAGE_W-1:0]  page_index;
   logic               found;
   logic [COUNT_W-1:0] dirty_count;
   logic [COUNT_W-1:0] ever_dirty_count;

   modport source (output valid, output page_index, output found, output dirty_count,
                   output ever_dirty_count, input ready);
   modport sink (input valid, input page_index, input found, input dirty_count,
                 input ever_dirty_count, output ready);
endinterface

>>> rtl/dirty_page_bitmap_tracker_unit.sv
// An in-range mark passes read, check and done; clear and reset-session go straight to done.
// Collect repeats read and check per word until a dirty word or the last word, then goes to done.
// No new item is taken until the last one has left done for the response register.
// The next item is taken while an earlier result still waits in the response register.
// Synchronous active-high reset empties both sets at once through the valid bits and counts.
`include "dirty_page_bitmap_tracker_unit_assert.svh"
module dirty_page_bitmap_tracker_unit import dpbt_pkg::*; (
   input logic      clock,
   input logic      reset,
   dpbt_req_if.sink   req_chan,
   dpbt_rsp_if.source rsp_chan
);

   // Sequencer states. Idle takes an item, read presents the store address, check
   // runs the bit unit on the read word and writes it back, done hands the result on.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [BIT_W-1:0]    bit_pos_ff, bit_pos_in;
   addr_type            scan_ff, scan_in;
   logic [PAGE_W-1:0]   idx_ff, idx_in;
   logic                found_ff, found_in;
   logic [COUNT_W-1:0]  frame_count_ff, frame_count_in;
   logic [COUNT_W-1:0]  session_count_ff, session_count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]   rsp_index_ff, rsp_index_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]  rsp_dirty_ff, rsp_dirty_in;
   logic [COUNT_W-1:0]  rsp_ever_ff, rsp_ever_in;

   dpbt_store_ctrl_type store_ctrl;
   dpbt_bit_res_type    bit_res;
   word_type            frame_rdata;
   word_type            session_rdata;
   logic                req_accept;
   logic [31:0]         page_word;
   logic                page_in_range;
   logic                scan_last;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // The word that holds the page; a page past the end of the bitmap is not marked.
   assign page_word     = 32'(req_chan.page_number >> BIT_W);
   assign page_in_range = (page_word < 32'(BITMAP_WORDS));
   assign scan_last     = (scan_ff == ADDR_W'(BITMAP_WORDS - 1));

   dpbt_bitmap_store u_store (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (store_ctrl),
      .frame_wdata   (bit_res.frame_word),
      .session_wdata (bit_res.session_word),
      .frame_rdata   (frame_rdata),
      .session_rdata (session_rdata)
   );

   // The one shared unit: marks set a bit in both words, collects strip the lowest bit.
   dpbt_bit_unit u_bit_unit (
      .op           ((cmd_ff == CMD_MARK) ? OP_SET : OP_CLEAR_LOW),
      .frame_word   (frame_rdata),
      .session_word (session_rdata),
      .bit_pos      (bit_pos_ff),
      .res          (bit_res)
   );

   always_comb begin
      state_in         = state_ff;
      cmd_in           = cmd_ff;
      bit_pos_in       = bit_pos_ff;
      scan_in          = scan_ff;
      idx_in           = idx_ff;
      found_in         = found_ff;
      frame_count_in   = frame_count_ff;
      session_count_in = session_count_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_index_in     = rsp_index_ff;
      rsp_found_in     = rsp_found_ff;
      rsp_dirty_in     = rsp_dirty_ff;
      rsp_ever_in      = rsp_ever_ff;

      store_ctrl               = '0;
      store_ctrl.rd_addr       = scan_ff;
      store_ctrl.wr_addr       = scan_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in     = req_chan.cmd;
               bit_pos_in = req_chan.page_number[BIT_W-1:0];
               idx_in     = '0;
               found_in   = 1'b0;
               case (req_chan.cmd)
                  CMD_MARK: begin
                     scan_in  = ADDR_W'(page_word);
                     state_in = page_in_range ? ST_READ : ST_DONE;
                  end
                  CMD_COLLECT: begin
                     scan_in  = '0;
                     state_in = ST_READ;
                  end
                  CMD_CLEAR_FRAME: begin
                     store_ctrl.clear_frame = 1'b1;
                     frame_count_in         = '0;
                     state_in               = ST_DONE;
                  end
                  default: begin
                     store_ctrl.clear_session = 1'b1;
                     frame_count_in           = '0;
                     session_count_in         = '0;
                     state_in                 = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (cmd_ff == CMD_MARK) begin
               store_ctrl.frame_we   = 1'b1;
               store_ctrl.session_we = 1'b1;
               frame_count_in   = frame_count_ff + COUNT_W'(bit_res.frame_fresh);
               session_count_in = session_count_ff + COUNT_W'(bit_res.session_fresh);
               state_in         = ST_DONE;
            end else if (bit_res.nonzero) begin
               store_ctrl.frame_we = 1'b1;
               idx_in              = PAGE_W'({scan_ff, bit_res.bit_index});
               found_in            = 1'b1;
               frame_count_in      = frame_count_ff - COUNT_W'(1);
               state_in            = ST_DONE;
            end else if (scan_last) begin
               state_in = ST_DONE;
            end else begin
               scan_in  = scan_ff + ADDR_W'(1);
               state_in = ST_READ;
            end
         end
         default: begin
            // Hand the result over once the response register is free or being emptied.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = idx_ff;
               rsp_found_in = found_ff;
               rsp_dirty_in = frame_count_ff;
               rsp_ever_in  = session_count_ff;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         frame_count_ff   <= '0;
         session_count_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         frame_count_ff   <= frame_count_in;
         session_count_ff <= session_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      bit_pos_ff   <= bit_pos_in;
      scan_ff      <= scan_in;
      idx_ff       <= idx_in;
      found_ff     <= found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_found_ff <= rsp_found_in;
      rsp_dirty_ff <= rsp_dirty_in;
      rsp_ever_ff  <= rsp_ever_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.page_index       = rsp_index_ff;
   assign rsp_chan.found            = rsp_found_ff;
   assign rsp_chan.dirty_count      = rsp_dirty_ff;
   assign rsp_chan.ever_dirty_count = rsp_ever_ff;

   // Every frame-dirty page is also session-dirty, so its count can never be larger.
   `DPBT_ASSERT_IMPLIES(a_frame_le_session, clock, reset, 1'b1, frame_count_ff <= session_count_ff)
   // Each bitmap is written only while the shared unit is checking a word.
   `DPBT_ASSERT_IMPLIES(a_frame_wr_in_check, clock, reset, store_ctrl.frame_we, state_ff == ST_CHECK)
   `DPBT_ASSERT_IMPLIES(a_sess_wr_in_check, clock, reset, store_ctrl.session_we, state_ff == ST_CHECK)
   // Once an item is taken, no further item is taken until its result is handed on.
   `DPBT_ASSERT_NEXT(a_one_item_at_a_time, clock, reset, req_accept, !req_chan.ready)

endmodule

>>> rtl/dpbt_bit_unit.sv
// Shared bit unit: sets a page bit in both words, or removes the lowest set bit.
module dpbt_bit_unit import dpbt_pkg::*; (
   input  logic             op,
   input  word_type         frame_word,
   input  word_type         session_word,
   input  logic [BIT_W-1:0] bit_pos,
   output dpbt_bit_res_type res
);

   word_type         word_dec;
   word_type         low_bit;
   word_type         mark_mask;
   logic [BIT_W-1:0] index;

   assign word_dec  = frame_word - word_type'(1);
   assign low_bit   = frame_word & ~word_dec;
   assign mark_mask = word_type'(1) << bit_pos;

   // The isolated low bit is one-hot, so OR-ing the positions encodes it.
   always_comb begin
      index = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (low_bit[j]) begin
            index = index | BIT_W'(j);
         end
      end
   end

   always_comb begin
      res.bit_index     = index;
      res.nonzero       = |frame_word;
      res.frame_fresh   = ~frame_word[bit_pos];
      res.session_fresh = ~session_word[bit_pos];
      if (op == OP_SET) begin
         res.frame_word   = frame_word | mark_mask;
         res.session_word = session_word | mark_mask;
      end else begin
         res.frame_word   = frame_word & word_dec;
         res.session_word = session_word;
      end
   end

endmodule

>>> rtl/dpbt_bitmap_store.sv
// Storage of the frame and session bitmaps, with per-word valid bits for fast clearing.
module dpbt_bitmap_store import dpbt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  dpbt_store_ctrl_type ctrl,
   input  word_type            frame_wdata,
   input  word_type            session_wdata,
   output word_type            frame_rdata,
   output word_type            session_rdata
);

   word_type                  frame_mem [BITMAP_WORDS];
   word_type                  session_mem [BITMAP_WORDS];
   logic [BITMAP_WORDS-1:0]   frame_vld_ff;
   logic [BITMAP_WORDS-1:0]   frame_vld_in;
   logic [BITMAP_WORDS-1:0]   session_vld_ff;
   logic [BITMAP_WORDS-1:0]   session_vld_in;
   word_type                  frame_rd_ff;
   word_type                  session_rd_ff;
   logic                      frame_rvld_ff;
   logic                      session_rvld_ff;

   always_ff @(posedge clock) begin
      if (ctrl.frame_we) begin
         frame_mem[ctrl.wr_addr] <= frame_wdata;
      end
      if (ctrl.session_we) begin
         session_mem[ctrl.wr_addr] <= session_wdata;
      end
      frame_rd_ff     <= frame_mem[ctrl.rd_addr];
      session_rd_ff   <= session_mem[ctrl.rd_addr];
      frame_rvld_ff   <= frame_vld_ff[ctrl.rd_addr];
      session_rvld_ff <= session_vld_ff[ctrl.rd_addr];
   end

   // A word whose valid bit is low has not been written since it was cleared.
   always_comb begin
      frame_vld_in   = frame_vld_ff;
      session_vld_in = session_vld_ff;
      if (ctrl.frame_we) begin
         frame_vld_in[ctrl.wr_addr] = 1'b1;
      end
      if (ctrl.session_we) begin
         session_vld_in[ctrl.wr_addr] = 1'b1;
      end
      if (ctrl.clear_frame || ctrl.clear_session) begin
         frame_vld_in = '0;
      end
      if (ctrl.clear_session) begin
         session_vld_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_vld_ff   <= '0;
         session_vld_ff <= '0;
      end else begin
         frame_vld_ff   <= frame_vld_in;
         session_vld_ff <= session_vld_in;
      end
   end

   assign frame_rdata   = frame_rvld_ff ? frame_rd_ff : '0;
   assign session_rdata = session_rvld_ff ? session_rd_ff : '0;

endmodule

>>> test/tb_dirty_page_bitmap_tracker_unit.sv
// Self-checking testbench for the dirty page bitmap tracker: random handshakes, scoreboard.
`timescale 1ns / 1ps

module tb_dirty_page_bitmap_tracker_unit;
   import dpbt_pkg::*;

   // One command waiting to be offered on the request channel. A set hold flag makes the
   // sender wait until every earlier result has been returned before it offers the item.
   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [PAGE_W-1:0] page;
      logic              hold;
   } page_cmd_type;

   // One result as the tracker should return it.
   typedef struct {
      logic [PAGE_W-1:0]  page_index;
      logic               found;
      logic [COUNT_W-1:0] dirty_count;
      logic [COUNT_W-1:0] ever_dirty_count;
   } tracker_result_type;

   localparam int PAGES        = BITMAP_WORDS * WORD_BITS;
   localparam int SETTLE_WAIT  = 4 * BITMAP_WORDS + 12;
   localparam int REPORT_LIMIT = 10;

   logic clock;
   logic reset;

   dpbt_req_if req_if ();
   dpbt_rsp_if rsp_if ();

   dirty_page_bitmap_tracker_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Our own copy of the two page sets, updated as each item is accepted.
   logic [PAGES-1:0] frame_pages;
   logic [PAGES-1:0] session_pages;

   page_cmd_type       pending_cmds[$];
   tracker_result_type expected_results[$];

   int mismatches;
   int stray_results;
   int cmds_taken;
   int results_seen;
   int collects_found;
   int collects_empty;
   int cmd_tally[4];
   int gap_left;
   int stall_left;
   int wait_now;
   int rsp_wait;
   bit took_item;
   bit ever_full;

   always #1 clock = ~clock;

   // Apply one command to the model sets and return the result it must produce.
   // A collect removes the lowest page of the frame set; every other command
   // leaves page_index and found at zero.
   function automatic tracker_result_type apply_page_cmd(input logic [CMD_W-1:0] cmd,
                                                         input logic [PAGE_W-1:0] page);
      tracker_result_type r;
      r.page_index = '0;
      r.found      = 1'b0;
      case (cmd)
         CMD_MARK: begin
            // With four words every 8-bit page number lies inside the bitmap.
            if (int'(page) < PAGES) begin
               frame_pages[page]   = 1'b1;
               session_pages[page] = 1'b1;
            end
         end
         CMD_COLLECT: begin
            for (int p = 0; p < PAGES; p++) begin
               if (frame_pages[p]) begin
                  frame_pages[p] = 1'b0;
                  r.page_index   = PAGE_W'(p);
                  r.found        = 1'b1;
                  break;
               end
            end
         end
         CMD_CLEAR_FRAME: begin
            frame_pages = '0;
         end
         default: begin
            frame_pages   = '0;
            session_pages = '0;
         end
      endcase
      r.dirty_count      = COUNT_W'($countones(frame_pages));
      r.ever_dirty_count = COUNT_W'($countones(session_pages));
      return r;
   endfunction

   // Idle length for either side: mostly none or short, now and then long. Every fourth
   // block of 64 handshakes gets zero from this function.
   function automatic int pick_gap(input int handshakes);
      int roll;
      if ((handshakes / 64) % 4 == 3) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 30);
   endfunction

   task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [PAGE_W-1:0] page,
                            input logic hold);
      page_cmd_type c;
      c.cmd  = cmd;
      c.page = page;
      c.hold = hold;
      pending_cmds = {pending_cmds, c};
   endtask

   // Request driver. The expected result is worked out at the edge at which the item is
   // accepted, so the model sees commands in exactly the order the tracker takes them.
   // The next item, or an idle cycle, is chosen only once the current one has gone.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid       <= 1'b0;
         req_if.cmd         <= CMD_MARK;
         req_if.page_number <= '0;
         gap_left           <= 0;
      end else begin
         took_item = req_if.valid && req_if.ready;
         if (took_item) begin
            expected_results = {expected_results,
                                apply_page_cmd(req_if.cmd, req_if.page_number)};
            cmd_tally[req_if.cmd]++;
            cmds_taken++;
            if (session_pages == '1) begin
               ever_full = 1'b1;
            end
         end
         if (took_item || !req_if.valid) begin
            wait_now = took_item ? pick_gap(cmds_taken) : gap_left;
            if (wait_now > 0) begin
               req_if.valid <= 1'b0;
               gap_left     <= wait_now - 1;
            end else if (pending_cmds.size() > 0 &&
                         !(pending_cmds[0].hold && expected_results.size() > 0)) begin
               req_if.valid       <= 1'b1;
               req_if.cmd         <= pending_cmds[0].cmd;
               req_if.page_number <= pending_cmds[0].page;
               void'(pending_cmds.pop_front());
               gap_left           <= 0;
            end else begin
               req_if.valid <= 1'b0;
               gap_left     <= 0;
            end
         end
      end
   end

   // Response monitor. Every accepted result is checked against the oldest expectation,
   // field by field. Ready is withdrawn at random, both straight after a result and
   // while a result is still being worked on.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               stray_results++;
               $display("ERROR: result with nothing expected: index %0d found %0b",
                        rsp_if.page_index, rsp_if.found,
                        " counts %0d/%0d", rsp_if.dirty_count, rsp_if.ever_dirty_count);
            end else begin
               if (expected_results[0].found) begin
                  collects_found++;
               end
               if (rsp_if.page_index       !== expected_results[0].page_index ||
                   rsp_if.found            !== expected_results[0].found ||
                   rsp_if.dirty_count      !== expected_results[0].dirty_count ||
                   rsp_if.ever_dirty_count !== expected_results[0].ever_dirty_count) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("MISMATCH result %0d: index %0d/%0d found %0b/%0b",
                              results_seen,
                              expected_results[0].page_index, rsp_if.page_index,
                              expected_results[0].found, rsp_if.found,
                              " dirty %0d/%0d ever %0d/%0d (expected/actual)",
                              expected_results[0].dirty_count, rsp_if.dirty_count,
                              expected_results[0].ever_dirty_count, rsp_if.ever_dirty_count);
                  end
               end
               void'(expected_results.pop_front());
            end
            rsp_wait = pick_gap(results_seen);
            if (rsp_wait > 0) begin
               rsp_if.ready <= 1'b0;
               stall_left   <= rsp_wait - 1;
            end else begin
               rsp_if.ready <= 1'b1;
            end
         end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
         end else if ($urandom_range(0, 15) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 3);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int order[PAGES];
      int roll;
      int tmp;
      int j;

      clock              = 1'b0;
      reset              = 1'b1;
      frame_pages        = '0;
      session_pages      = '0;
      mismatches         = 0;
      stray_results      = 0;
      cmds_taken         = 0;
      results_seen       = 0;
      collects_found     = 0;
      collects_empty     = 0;
      ever_full          = 1'b0;
      cmd_tally          = '{default: 0};

      // Directed opening: a collect on the empty set, marks at both ends and on every
      // word boundary, a repeated mark, ascending collects, clearing the frame set both when
      // it holds pages and when it is empty, and resetting the session. Page numbers on
      // commands other than mark are mostly non-zero, as they must be ignored.
      queue_cmd(CMD_COLLECT, 8'hFF, 1'b0);
      queue_cmd(CMD_MARK, 8'd0, 1'b0);
      queue_cmd(CMD_MARK, 8'd255, 1'b0);
      queue_cmd(CMD_MARK, 8'd63, 1'b0);
      queue_cmd(CMD_MARK, 8'd64, 1'b0);
      queue_cmd(CMD_MARK, 8'd0, 1'b0);
      queue_cmd(CMD_MARK, 8'd128, 1'b0);
      queue_cmd(CMD_MARK, 8'd191, 1'b0);
      queue_cmd(CMD_MARK, 8'd192, 1'b0);
      queue_cmd(CMD_COLLECT, 8'h0F, 1'b0);
      queue_cmd(CMD_COLLECT, 8'hF0, 1'b0);
      queue_cmd(CMD_COLLECT, 8'h00, 1'b0);
      queue_cmd(CMD_CLEAR_FRAME, 8'hAA, 1'b0);
      queue_cmd(CMD_COLLECT, 8'h40, 1'b0);
      queue_cmd(CMD_MARK, 8'd127, 1'b0);
      queue_cmd(CMD_COLLECT, 8'h7F, 1'b0);
      queue_cmd(CMD_RESET_SESSION, 8'h55, 1'b0);
      queue_cmd(CMD_COLLECT, 8'h01, 1'b0);
      queue_cmd(CMD_MARK, 8'd200, 1'b0);
      queue_cmd(CMD_COLLECT, 8'hC8, 1'b0);
      queue_cmd(CMD_COLLECT, 8'hFF, 1'b0);
      queue_cmd(CMD_CLEAR_FRAME, 8'h00, 1'b0);
      queue_cmd(CMD_RESET_SESSION, 8'hFF, 1'b0);

      // Fill every page in shuffled order so that both counts reach their top value and
      // bit 8 of each count is exercised. The sender first waits for the directed part.
      for (int p = 0; p < PAGES; p++) begin
         order[p] = p;
      end
      for (int p = PAGES - 1; p > 0; p--) begin
         j        = $urandom_range(0, p);
         tmp      = order[p];
         order[p] = order[j];
         order[j] = tmp;
      end
      for (int p = 0; p < PAGES; p++) begin
         queue_cmd(CMD_MARK, PAGE_W'(order[p]), p == 0);
      end
      for (int n = 0; n < 40; n++) begin
         queue_cmd(CMD_COLLECT, PAGE_W'($urandom), 1'b0);
      end

      // Random traffic: mostly marks and collects, so the sets stay populated and
      // collects keep finding pages across all words; clears and session resets are
      // rare. Now and then the sender waits for every outstanding result.
      for (int n = 0; n < 220; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            queue_cmd(CMD_MARK, PAGE_W'($urandom), $urandom_range(0, 99) == 0);
         end else if (roll < 90) begin
            queue_cmd(CMD_COLLECT, PAGE_W'($urandom), 1'b0);
         end else if (roll < 96) begin
            queue_cmd(CMD_CLEAR_FRAME, PAGE_W'($urandom), 1'b0);
         end else begin
            queue_cmd(CMD_RESET_SESSION, PAGE_W'($urandom), 1'b0);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() > 0 || req_if.valid || expected_results.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_WAIT) @(posedge clock);

      collects_empty = cmd_tally[CMD_COLLECT] - collects_found;
      $display("Run covered %0d items: %0d marks, %0d collects (%0d found a page, %0d empty),",
               cmds_taken, cmd_tally[CMD_MARK], cmd_tally[CMD_COLLECT], collects_found,
               collects_empty);
      $display("%0d frame clears, %0d session resets; every page was dirty at once: %0s.",
               cmd_tally[CMD_CLEAR_FRAME], cmd_tally[CMD_RESET_SESSION],
               ever_full ? "yes" : "no");
      if (mismatches == 0 && stray_results == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d unexpected results", mismatches, stray_results);
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, with every gap and stall at its longest.
   initial begin
      #1_000_000;
      $display("Timeout with %0d items pending and %0d results outstanding",
               pending_cmds.size(), expected_results.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/dpbt_pkg.sv
rtl/dpbt_channel_ifs.sv
rtl/dpbt_bit_unit.sv
rtl/dpbt_bitmap_store.sv
rtl/dirty_page_bitmap_tracker_unit.sv
test/tb_dirty_page_bitmap_tracker_unit.sv
